// ----- hdl/assert_macros.svh -----
// assertion macros used by the evaluator module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/see_pkg.sv -----
// shared types, constants and helper functions of the expression evaluator
package see_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int VAR_COUNT   = 256;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int AW          = $clog2(STACK_DEPTH);

	localparam int Q_ONE       = 65536;
	localparam int TWO_PI_Q16  = 411775;
	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int GAIN_Q30    = 652032874;

	localparam int CW    = 34;
	localparam int DVS_W = CW;
	localparam int DVD_W = CW + 16;
	localparam int SQ_W  = 48;
	localparam int SQ_RW = SQ_W / 2;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [4:0] {
		OP_PUSH_NUM = 5'd0,
		OP_PUSH_VAR = 5'd1,
		OP_PUSH_IDX = 5'd2,
		OP_NEG      = 5'd3,
		OP_NOT      = 5'd4,
		OP_SET      = 5'd5,
		OP_ADD      = 5'd6,
		OP_SUB      = 5'd7,
		OP_MUL      = 5'd8,
		OP_GT       = 5'd9,
		OP_LT       = 5'd10,
		OP_GE       = 5'd11,
		OP_LE       = 5'd12,
		OP_EQ       = 5'd13,
		OP_NE       = 5'd14,
		OP_AND      = 5'd15,
		OP_OR       = 5'd16,
		OP_DIV      = 5'd17,
		OP_SIN      = 5'd18,
		OP_COS      = 5'd19,
		OP_TAN      = 5'd20,
		OP_SQRT     = 5'd21,
		OP_MIN      = 5'd22,
		OP_MAX      = 5'd23,
		OP_CLAMP    = 5'd24
	} op_t;

	// saturate to int32, msb flags saturation
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'(S32_MAX)) begin
			r = {1'b1, S32_MAX};
		end else if (v < 64'(S32_MIN)) begin
			r = {1'b1, S32_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic signed [31:0] boolq(input logic b);
		return b ? 32'(Q_ONE) : 32'sd0;
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/see_ram.sv -----
// generic single-port-write ram with registered read
module see_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/see_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module see_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [see_pkg::DVD_W-1:0] dividend,
	input  logic [see_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [see_pkg::DVD_W-1:0] quotient
);
	import see_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};
	assign ge     = !diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- hdl/see_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
module see_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [see_pkg::SQ_W-1:0]  radicand,
	output logic                      done,
	output logic [see_pkg::SQ_RW-1:0] root
);
	import see_pkg::*;

	localparam int RW    = SQ_RW + 3;
	localparam int CNT_W = $clog2(SQ_RW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0]  rad_q;
	logic [SQ_RW-1:0] root_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    rem_sh;
	logic [RW-1:0]    trial;
	logic             ge;

	assign rem_sh = {rem_q[RW-3:0], rad_q[SQ_W-1:SQ_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			root_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= radicand;
				root_q <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[SQ_RW-2:0], ge};
				rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQ_RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hdl/see_cordic.sv -----
// angle reduction and iterative cordic rotation for sine and cosine
module see_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [31:0]            angle,
	output logic                          done,
	output logic signed [see_pkg::CW-1:0] cos_q30,
	output logic signed [see_pkg::CW-1:0] sin_q30
);
	import see_pkg::*;

	localparam int RW = 21;
	localparam logic signed [RW-1:0] K_2PI  = RW'(TWO_PI_Q16);
	localparam logic signed [RW-1:0] K_PI   = RW'(PI_Q16);
	localparam logic signed [RW-1:0] K_HPI  = RW'(HALF_PI_Q16);
	localparam logic [31:0]          K_BASE = 32'(TWO_PI_Q16);

	typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ITER} cst_t;

	cst_t                 state_q;
	logic                 done_q;
	logic                 neg_q;
	logic                 flip_q;
	logic [31:0]          mag_q;
	logic [3:0]           k_q;
	logic [4:0]           i_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;

	logic [31:0]          sub;
	logic signed [RW-1:0] r0;
	logic signed [RW-1:0] r1;
	logic signed [RW-1:0] r2;
	logic signed [RW-1:0] rf;
	logic                 fl;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [CW-1:0] at;

	always_comb begin
		sub = K_BASE << k_q;
		r0  = neg_q ? -$signed({2'b00, mag_q[18:0]}) : $signed({2'b00, mag_q[18:0]});
		r1  = (r0 > K_PI) ? r0 - K_2PI : r0;
		r2  = (r1 < -K_PI) ? r1 + K_2PI : r1;
		fl  = 1'b0;
		rf  = r2;
		if (r2 > K_HPI) begin
			rf = K_PI - r2;
			fl = 1'b1;
		end else if (r2 < -K_HPI) begin
			rf = -K_PI - r2;
			fl = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = $signed({2'b00, atan_q30(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			neg_q   <= 1'b0;
			flip_q  <= 1'b0;
			mag_q   <= '0;
			k_q     <= '0;
			i_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						neg_q   <= angle[31];
						mag_q   <= angle[31] ? 32'(-angle) : 32'(angle);
						k_q     <= 4'd12;
						state_q <= C_RED;
					end
				end
				C_RED: begin
					if (mag_q >= sub) begin
						mag_q <= mag_q - sub;
					end
					k_q <= k_q - 1'b1;
					if (k_q == '0) begin
						state_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					flip_q  <= fl;
					z_q     <= {{(CW-RW){rf[RW-1]}}, rf} <<< 14;
					x_q     <= CW'(GAIN_Q30);
					y_q     <= '0;
					i_q     <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					if (!z_q[CW-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					i_q <= i_q + 1'b1;
					if (i_q == 5'd31) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign cos_q30 = flip_q ? -x_q : x_q;
	assign sin_q30 = y_q;

endmodule

// ----- hdl/stack_expression_evaluator.sv -----
// Q16.16 stack-machine evaluator: one instruction per input item, one result item each.
// Usage:
//   input channel in_valid/in_ready carries mode, number, var_value, var_index, last.
//   output channel out_valid/out_ready carries var_write, write_index, write_value,
//   result_value, done_res and error; every input item yields exactly one output item.
//   the operand stack sits in a 16-entry ram with registered read; the top entry is
//   also held in a register, the next two are read from the ram on every item.
// Work per item, between the stack reads and the commit:
//   push, simple arithmetic, compares, logic, set, min/max/clamp: combinational execute
//   mul: one registered 32x32 product, then shift and saturate
//   div: 50-step restoring divider
//   sqrt: 24-step root unit
//   sin/cos: 13-step angle reduction, fold, 32 cordic steps
//   tan: cordic followed by the divider
//   a new item is accepted the cycle after the previous one is committed.
// Reset empties the stack; ram contents are not cleared and unwritten entries are never used.
// A stalled output holds its item; the next instruction runs but waits to commit
// until the output register is free.
`include "assert_macros.svh"

module stack_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         mode,
	input  logic signed [31:0] number,
	input  logic signed [31:0] var_value,
	input  logic [7:0]         var_index,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               var_write,
	output logic [7:0]         write_index,
	output logic signed [31:0] write_value,
	output logic signed [31:0] result_value,
	output logic               done_res,
	output logic               error
);
	import see_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDC, S_EXEC, S_MUL, S_DIV, S_CORD, S_SQRT, S_COMMIT
	} st_t;

	function automatic logic [1:0] need_of(input op_t m);
		logic [1:0] n;
		unique case (m) inside
			OP_NEG, OP_NOT, OP_SIN, OP_COS, OP_TAN, OP_SQRT: n = 2'd1;
			OP_CLAMP: n = 2'd3;
			default: n = 2'd2;
		endcase
		return n;
	endfunction

	localparam logic signed [CW-1:0] RND = CW'(8192);
	localparam logic [15:0]          VMASK = 16'(VAR_COUNT - 1);

	st_t                state_q;
	op_t                mode_q;
	logic signed [31:0] number_q;
	logic signed [31:0] var_value_q;
	logic [7:0]         var_index_q;
	logic               last_q;
	logic [SP_W-1:0]    sp_q;
	logic [SP_W-1:0]    nsp_q;
	logic signed [31:0] top_q;
	logic signed [31:0] a_q;
	logic signed [31:0] c_q;
	logic signed [31:0] res_q;
	logic               err_q;
	logic               wr_q;
	logic               vw_q;
	logic [7:0]         widx_q;
	logic signed [31:0] wval_q;
	logic signed [63:0] prod_q;
	logic               dneg_q;

	logic               out_valid_q;
	logic               var_write_q;
	logic [7:0]         write_index_q;
	logic signed [31:0] write_value_q;
	logic signed [31:0] result_value_q;
	logic               done_res_q;
	logic               error_q;

	logic               accept;
	logic               out_free;
	logic               commit_go;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_rdata;
	logic [SP_W-1:0]    sp_m2;
	logic [SP_W-1:0]    sp_m3;
	logic [SP_W-1:0]    nsp_m1;
	logic [1:0]         need;
	logic               underflow;
	logic               is_push;
	logic               is_op;
	logic signed [31:0] push_val;
	logic [15:0]        set_idx16;
	logic signed [31:0] ex_res;
	logic               ex_err;
	logic signed [31:0] newtop;

	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic               div_done;
	logic [DVD_W-1:0]   div_q;
	logic signed [31:0] div_res;
	logic               div_err;
	logic               cor_start;
	logic               cor_done;
	logic signed [CW-1:0] cor_c;
	logic signed [CW-1:0] cor_s;
	logic signed [CW-1:0] sin_w;
	logic signed [CW-1:0] cos_w;
	logic [CW-1:0]      a_abs;
	logic [CW-1:0]      t_abs;
	logic [CW-1:0]      s_abs;
	logic [CW-1:0]      c_abs;
	logic               sq_start;
	logic               sq_done;
	logic [SQ_RW-1:0]   sq_root;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign commit_go = (state_q == S_COMMIT) && out_free;

	assign sp_m2     = sp_q - SP_W'(2);
	assign sp_m3     = sp_q - SP_W'(3);
	assign nsp_m1    = nsp_q - SP_W'(1);
	assign ram_re    = accept || (state_q == S_RDA);
	assign ram_raddr = accept ? sp_m2[AW-1:0] : sp_m3[AW-1:0];
	assign ram_we    = commit_go && wr_q;
	assign ram_waddr = nsp_m1[AW-1:0];

	assign need      = need_of(mode_q);
	assign underflow = sp_q < SP_W'(need);
	assign is_push   = mode_q <= OP_PUSH_IDX;
	assign is_op     = !is_push && (mode_q <= OP_CLAMP);
	assign set_idx16 = a_q[31:16] & VMASK;
	assign newtop    = wr_q ? res_q : top_q;

	always_comb begin
		unique case (mode_q)
			OP_PUSH_NUM: push_val = number_q;
			OP_PUSH_VAR: push_val = var_value_q;
			default:     push_val = 32'({var_index_q, 16'h0000});
		endcase
	end

	always_comb begin
		ex_res = '0;
		ex_err = 1'b0;
		case (mode_q)
			OP_NEG:   {ex_err, ex_res} = sat32(-64'(top_q));
			OP_NOT:   ex_res = boolq(top_q == 0);
			OP_SET:   ex_res = top_q;
			OP_ADD:   {ex_err, ex_res} = sat32(64'(a_q) + 64'(top_q));
			OP_SUB:   {ex_err, ex_res} = sat32(64'(a_q) - 64'(top_q));
			OP_GT:    ex_res = boolq(a_q > top_q);
			OP_LT:    ex_res = boolq(a_q < top_q);
			OP_GE:    ex_res = boolq(a_q >= top_q);
			OP_LE:    ex_res = boolq(a_q <= top_q);
			OP_EQ:    ex_res = boolq(a_q == top_q);
			OP_NE:    ex_res = boolq(a_q != top_q);
			OP_AND:   ex_res = boolq((a_q != 0) && (top_q != 0));
			OP_OR:    ex_res = boolq((a_q != 0) || (top_q != 0));
			OP_MIN:   ex_res = (a_q < top_q) ? a_q : top_q;
			OP_MAX:   ex_res = (a_q > top_q) ? a_q : top_q;
			OP_CLAMP: ex_res = (c_q < a_q) ? a_q : ((top_q < c_q) ? top_q : c_q);
			// divide by zero
			OP_DIV: begin
				ex_err = 1'b1;
				ex_res = a_q[31] ? S32_MIN : S32_MAX;
			end
			// negative root
			OP_SQRT: begin
				ex_err = 1'b1;
				ex_res = '0;
			end
			default: ;
		endcase
	end

	// divider operands, shared by div and tan
	always_comb begin
		a_abs = a_q[31] ? CW'(-64'(a_q)) : CW'(64'(a_q));
		t_abs = top_q[31] ? CW'(-64'(top_q)) : CW'(64'(top_q));
		s_abs = cor_s[CW-1] ? CW'(-cor_s) : CW'(cor_s);
		c_abs = cor_c[CW-1] ? CW'(-cor_c) : CW'(cor_c);
		div_start = ((state_q == S_EXEC) && (mode_q == OP_DIV) && !underflow && (top_q != 0))
			|| ((state_q == S_CORD) && cor_done && (mode_q == OP_TAN) && (cor_c != 0));
		div_dvd = (state_q == S_EXEC) ? {a_abs, 16'h0000} : {s_abs, 16'h0000};
		div_dvs = (state_q == S_EXEC) ? t_abs : c_abs;
	end

	always_comb begin
		div_err = 1'b0;
		if (dneg_q) begin
			if (div_q > DVD_W'(64'h8000_0000)) begin
				div_err = 1'b1;
				div_res = S32_MIN;
			end else begin
				div_res = -$signed(div_q[31:0]);
			end
		end else begin
			if (div_q > DVD_W'(64'h7FFF_FFFF)) begin
				div_err = 1'b1;
				div_res = S32_MAX;
			end else begin
				div_res = $signed(div_q[31:0]);
			end
		end
	end

	assign cor_start = (state_q == S_EXEC) && !underflow
		&& ((mode_q == OP_SIN) || (mode_q == OP_COS) || (mode_q == OP_TAN));
	assign sq_start  = (state_q == S_EXEC) && !underflow && (mode_q == OP_SQRT) && !top_q[31];
	assign sin_w     = (cor_s + RND) >>> 14;
	assign cos_w     = (cor_c + RND) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= OP_PUSH_NUM;
			number_q       <= '0;
			var_value_q    <= '0;
			var_index_q    <= '0;
			last_q         <= 1'b0;
			sp_q           <= '0;
			nsp_q          <= '0;
			top_q          <= '0;
			a_q            <= '0;
			c_q            <= '0;
			res_q          <= '0;
			err_q          <= 1'b0;
			wr_q           <= 1'b0;
			vw_q           <= 1'b0;
			widx_q         <= '0;
			wval_q         <= '0;
			prod_q         <= '0;
			dneg_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			var_write_q    <= 1'b0;
			write_index_q  <= '0;
			write_value_q  <= '0;
			result_value_q <= '0;
			done_res_q     <= 1'b0;
			error_q        <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !commit_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q      <= op_t'(mode);
						number_q    <= number;
						var_value_q <= var_value;
						var_index_q <= var_index;
						last_q      <= last;
						state_q     <= S_RDA;
					end
				end
				S_RDA: begin
					a_q     <= ram_rdata;
					state_q <= S_RDC;
				end
				S_RDC: begin
					c_q     <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					vw_q    <= 1'b0;
					widx_q  <= '0;
					wval_q  <= '0;
					err_q   <= 1'b0;
					wr_q    <= 1'b0;
					nsp_q   <= sp_q;
					state_q <= S_COMMIT;
					if (is_push) begin
						if (sp_q == SP_W'(STACK_DEPTH)) begin
							err_q <= 1'b1;
						end else begin
							wr_q  <= 1'b1;
							res_q <= push_val;
							nsp_q <= sp_q + 1'b1;
						end
					end else if (is_op) begin
						if (underflow) begin
							err_q <= 1'b1;
						end else begin
							wr_q  <= 1'b1;
							nsp_q <= sp_q - SP_W'(need) + 1'b1;
							res_q <= ex_res;
							err_q <= ex_err;
							case (mode_q)
								OP_SET: begin
									vw_q   <= 1'b1;
									widx_q <= set_idx16[7:0];
									wval_q <= top_q;
								end
								OP_MUL: begin
									prod_q  <= a_q * top_q;
									state_q <= S_MUL;
								end
								OP_DIV: begin
									dneg_q <= a_q[31] ^ top_q[31];
									if (top_q != 0) begin
										state_q <= S_DIV;
									end
								end
								OP_SIN, OP_COS, OP_TAN: state_q <= S_CORD;
								OP_SQRT: begin
									if (!top_q[31]) begin
										state_q <= S_SQRT;
									end
								end
								default: ;
							endcase
						end
					end
				end
				S_MUL: begin
					{err_q, res_q} <= sat32(prod_q >>> 16);
					state_q        <= S_COMMIT;
				end
				S_DIV: begin
					if (div_done) begin
						err_q   <= div_err;
						res_q   <= div_res;
						state_q <= S_COMMIT;
					end
				end
				S_CORD: begin
					if (cor_done) begin
						state_q <= S_COMMIT;
						case (mode_q)
							OP_SIN: res_q <= sin_w[31:0];
							OP_COS: res_q <= cos_w[31:0];
							default: begin
								if (cor_c == 0) begin
									err_q <= 1'b1;
									res_q <= cor_s[CW-1] ? S32_MIN : S32_MAX;
								end else begin
									dneg_q  <= cor_s[CW-1] ^ cor_c[CW-1];
									state_q <= S_DIV;
								end
							end
						endcase
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						err_q   <= 1'b0;
						res_q   <= 32'(sq_root);
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						if (wr_q) begin
							top_q <= res_q;
						end
						sp_q           <= last_q ? '0 : nsp_q;
						out_valid_q    <= 1'b1;
						var_write_q    <= vw_q;
						write_index_q  <= widx_q;
						write_value_q  <= wval_q;
						result_value_q <= (last_q && (nsp_q != '0)) ? newtop : '0;
						done_res_q     <= last_q;
						error_q        <= err_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	see_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (res_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	see_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	see_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (top_q),
		.done    (cor_done),
		.cos_q30 (cor_c),
		.sin_q30 (cor_s)
	);

	see_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (SQ_W'({top_q[30:0], 16'h0000})),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign out_valid    = out_valid_q;
	assign var_write    = var_write_q;
	assign write_index  = write_index_q;
	assign write_value  = write_value_q;
	assign result_value = result_value_q;
	assign done_res     = done_res_q;
	assign error        = error_q;

	`CHK_IMPL(a_no_rw_clash, ram_we, !ram_re, "stack ram read and write in the same cycle")
	`CHK_IMPL(a_sp_bound, state_q == S_IDLE, sp_q <= SP_W'(STACK_DEPTH), "stack pointer past depth")
	`CHK_NEXT(a_last_empties, commit_go && last_q, sp_q == '0, "last item left stack entries")

endmodule

// ----- sim/tb_stack_expression_evaluator.sv -----
// testbench for the Q16.16 stack expression evaluator: directed and random programs against a predictor
`timescale 1ns / 100ps

module tb_stack_expression_evaluator;
	import see_pkg::*;

	typedef struct packed {
		logic               var_write;
		logic [7:0]         write_index;
		logic signed [31:0] write_value;
		logic signed [31:0] result_value;
		logic               done_res;
		logic               error;
	} eval_result_t;

	class eval_scoreboard;
		eval_result_t pending[$];
		logic signed [31:0] stk[STACK_DEPTH];
		int unsigned depth;
		int errors;
		int checked;

		function new();
			depth = 0;
			errors = 0;
			checked = 0;
		endfunction

		static function logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
			return v >>> s;
		endfunction

		static function logic signed [31:0] clip(logic signed [63:0] v, inout logic e);
			if (v > 64'sd2147483647) begin
				e = 1'b1;
				return S32_MAX;
			end
			if (v < -64'sd2147483648) begin
				e = 1'b1;
				return S32_MIN;
			end
			return v[31:0];
		endfunction

		static function logic signed [31:0] truth(logic b);
			return b ? 32'sd65536 : 32'sd0;
		endfunction

		static function logic [31:0] atan_entry(int i);
			logic [31:0] tbl[32] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
				32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA,
				32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF,
				32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF,
				32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
				32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004,
				32'h00000002, 32'h00000001, 32'h00000000};
			return tbl[i];
		endfunction

		static function void rotate(logic signed [31:0] ang, output logic signed [63:0] c30,
				output logic signed [63:0] s30);
			logic signed [63:0] r, x, y, z, dx, dy;
			logic flip;
			r = 64'(ang) % 64'sd411775;
			x = 64'sd652032874;
			y = 0;
			flip = 1'b0;
			if (r > 64'sd205887) r = r - 64'sd411775;
			if (r < -64'sd205887) r = r + 64'sd411775;
			if (r > 64'sd102944) begin
				r = 64'sd205887 - r;
				flip = 1'b1;
			end else if (r < -64'sd102944) begin
				r = -64'sd205887 - r;
				flip = 1'b1;
			end
			z = r * 64'sd16384;
			for (int i = 0; i < 32; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - 64'(atan_entry(i));
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + 64'(atan_entry(i));
				end
			end
			c30 = flip ? -x : x;
			s30 = y;
		endfunction

		static function logic [63:0] root64(logic [63:0] n);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void note_input(logic [4:0] md, logic signed [31:0] num,
				logic signed [31:0] vv, logic [7:0] vi, logic lst);
			eval_result_t o;
			logic signed [31:0] t, a, c, v;
			logic signed [63:0] aa, bb, r, c30, s30;
			logic e;
			int unsigned need;
			o = '0;
			e = 1'b0;
			if (md <= OP_PUSH_IDX) begin
				v = (md == OP_PUSH_NUM) ? num : (md == OP_PUSH_VAR) ? vv : {8'd0, vi, 16'd0};
				if (depth >= STACK_DEPTH) e = 1'b1;
				else begin
					stk[depth] = v;
					depth++;
				end
			end else if (md <= OP_CLAMP) begin
				need = (md == OP_NEG || md == OP_NOT || (md >= OP_SIN && md <= OP_SQRT)) ? 1 :
					(md == OP_CLAMP ? 3 : 2);
				if (depth < need) e = 1'b1;
				else begin
					t = stk[depth-1];
					a = need >= 2 ? stk[depth-2] : t;
					c = need >= 3 ? stk[depth-3] : t;
					aa = a;
					bb = t;
					r = 0;
					case (op_t'(md))
						OP_NEG: r = clip(-bb, e);
						OP_NOT: r = truth(t == 0);
						OP_SET: begin
							o.var_write = 1'b1;
							o.write_index = a[23:16];
							o.write_value = t;
							r = t;
						end
						OP_ADD: r = clip(aa + bb, e);
						OP_SUB: r = clip(aa - bb, e);
						OP_MUL: r = clip((aa * bb) >>> 16, e);
						OP_GT: r = truth(a > t);
						OP_LT: r = truth(a < t);
						OP_GE: r = truth(a >= t);
						OP_LE: r = truth(a <= t);
						OP_EQ: r = truth(a == t);
						OP_NE: r = truth(a != t);
						OP_AND: r = truth(a != 0 && t != 0);
						OP_OR: r = truth(a != 0 || t != 0);
						OP_DIV: begin
							if (t == 0) begin
								e = 1'b1;
								r = a >= 0 ? S32_MAX : S32_MIN;
							end else r = clip((aa * 64'sd65536) / bb, e);
						end
						OP_SIN: begin
							rotate(t, c30, s30);
							r = clip((s30 + 8192) >>> 14, e);
						end
						OP_COS: begin
							rotate(t, c30, s30);
							r = clip((c30 + 8192) >>> 14, e);
						end
						OP_TAN: begin
							rotate(t, c30, s30);
							if (c30 == 0) begin
								e = 1'b1;
								r = s30 >= 0 ? S32_MAX : S32_MIN;
							end else r = clip((s30 * 64'sd65536) / c30, e);
						end
						OP_SQRT: begin
							if (t < 0) begin
								e = 1'b1;
								r = 0;
							end else r = $signed(root64(64'(bb) << 16));
						end
						OP_MIN: r = a < t ? a : t;
						OP_MAX: r = a > t ? a : t;
						default: r = c < a ? a : (t < c ? t : c);
					endcase
					depth = depth - need;
					stk[depth] = r[31:0];
					depth++;
				end
			end
			if (lst) begin
				o.done_res = 1'b1;
				o.result_value = depth > 0 ? stk[depth-1] : 32'sd0;
				depth = 0;
			end
			o.error = e;
			pending.push_back(o);
		endfunction

		function void check_result(eval_result_t got);
			eval_result_t exp;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.var_write !== exp.var_write) begin
				$error("var_write exp %0d got %0d", exp.var_write, got.var_write);
				errors++;
			end
			if (got.write_index !== exp.write_index) begin
				$error("write_index exp %0d got %0d", exp.write_index, got.write_index);
				errors++;
			end
			if (got.write_value !== exp.write_value) begin
				$error("write_value exp %h got %h", exp.write_value, got.write_value);
				errors++;
			end
			if (got.result_value !== exp.result_value) begin
				$error("result_value exp %h got %h", exp.result_value, got.result_value);
				errors++;
			end
			if (got.done_res !== exp.done_res) begin
				$error("done_res exp %0d got %0d", exp.done_res, got.done_res);
				errors++;
			end
			if (got.error !== exp.error) begin
				$error("error exp %0d got %0d", exp.error, got.error);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [4:0] mode = '0;
	logic signed [31:0] number = '0;
	logic signed [31:0] var_value = '0;
	logic [7:0] var_index = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic var_write;
	logic [7:0] write_index;
	logic signed [31:0] write_value;
	logic signed [31:0] result_value;
	logic done_res;
	logic error;

	eval_scoreboard sb = new();
	int send_idle = 26;
	int recv_idle = 46;
	bit hold_recv = 0;
	int sent = 0;

	always #10 clk = ~clk;

	stack_expression_evaluator DUT (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({var_write, write_index, write_value, result_value, done_res, error});
		if (arst_n)
			out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
	end

	// valid stays high after acceptance until the next idle cycle or drain drops it
	task automatic send_item(logic [4:0] md, logic signed [31:0] num,
			logic signed [31:0] vv, logic [7:0] vi, logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		number <= num;
		var_value <= vv;
		var_index <= vi;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(md, num, vv, vi, lst);
		sent++;
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(5))
			0: return $urandom();
			1: return S32_MAX;
			2: return S32_MIN;
			3: return 0;
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	task automatic push_rand();
		send_item(5'($urandom_range(2)), rand_q(), rand_q(), 8'($urandom()), 1'b0);
	endtask

	// random program: pushes first, then a mix of pushes and ops, and a final item of any mode with last set
	task automatic rand_program();
		int n, d;
		logic [4:0] md;
		n = $urandom_range(1, 8);
		d = 0;
		for (int i = 0; i < n; i++) begin
			if (d < 3 || $urandom_range(2) == 0) begin
				push_rand();
				d++;
			end else begin
				md = 5'($urandom_range(OP_NEG, OP_CLAMP));
				send_item(md, rand_q(), rand_q(), 8'($urandom()), 1'b0);
			end
		end
		md = 5'($urandom_range(31));
		send_item(md, rand_q(), rand_q(), 8'($urandom()), 1'b1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	initial begin
		#2000000000;
		$display("tb_stack_expression_evaluator: done, errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, every opcode, underflow, overflow, div by zero, negative root
		send_item(OP_ADD, 0, 0, 0, 1'b0);
		send_item(OP_PUSH_NUM, S32_MAX, 0, 0, 1'b0);
		send_item(OP_PUSH_NUM, S32_MAX, 0, 0, 1'b0);
		send_item(OP_ADD, 0, 0, 0, 1'b1);
		send_item(OP_PUSH_NUM, S32_MIN, 0, 0, 1'b0);
		send_item(OP_NEG, 0, 0, 0, 1'b1);
		send_item(OP_PUSH_VAR, 0, -32'sd65536, 0, 1'b0);
		send_item(OP_SQRT, 0, 0, 0, 1'b1);
		send_item(OP_PUSH_NUM, -5, 0, 0, 1'b0);
		send_item(OP_PUSH_NUM, 0, 0, 0, 1'b0);
		send_item(OP_DIV, 0, 0, 0, 1'b1);
		send_item(OP_PUSH_IDX, 0, 0, 8'hFF, 1'b0);
		send_item(OP_PUSH_NUM, 32'sd102944, 0, 0, 1'b0);
		send_item(OP_SET, 0, 0, 0, 1'b1);
		for (int i = 0; i < 17; i++) send_item(OP_PUSH_IDX, 0, 0, 8'(i), 1'b0);
		send_item(5'd31, 0, 0, 0, 1'b1);
		send_item(5'd25, 0, 0, 0, 1'b1);
		for (int m = OP_NEG; m <= OP_CLAMP; m++) begin
			push_rand();
			push_rand();
			push_rand();
			send_item(5'(m), 0, 0, 0, 1'b1);
		end
		send_item(OP_PUSH_NUM, 32'sd102944, 0, 0, 1'b0);
		send_item(OP_TAN, 0, 0, 0, 1'b1);
		wait_drain();
		// long receiver hold-off while items keep coming
		fork
			begin
				hold_recv = 1;
				repeat (400) @(posedge clk);
				hold_recv = 0;
			end
			repeat (6) rand_program();
		join
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 26 : ph == 1 ? 46 : 0;
			recv_idle = ph == 0 ? 46 : ph == 1 ? 26 : 0;
			while (sent < 200 + (ph + 1) * 330) begin
				if ($urandom_range(9) == 0)
					send_item(5'($urandom()), $urandom(), $urandom(), 8'($urandom()),
						1'($urandom()));
				else
					rand_program();
			end
		end
		wait_drain();
		$display("covered %0d items, %0d results checked across three idling phases",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_stack_expression_evaluator: done, clean");
		else
			$display("tb_stack_expression_evaluator: done, errors");
		$finish;
	end
endmodule
